// ----- sv/lcwc_pkg.sv -----
`default_nettype none
package lcwc_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 8;

  // average is unsigned Q(SAMPLE_BITS).(FRACTION_BITS)
  localparam int ACC_W    = SAMPLE_BITS + FRACTION_BITS;
  localparam int GAIN_W   = 16;
  localparam int SLOPE_W  = 16;
  localparam int COUNT_W  = 8;
  localparam int TSUM_W   = SAMPLE_BITS + COUNT_W;
  localparam int DIV_W    = (ACC_W > TSUM_W) ? ACC_W : TSUM_W;
  localparam int QX_W     = (DIV_W > 33) ? DIV_W : 33;
  localparam int DCNT_W   = $clog2(DIV_W);
  localparam int PROD_W   = ACC_W + GAIN_W + 2;
  localparam int WEIGHT_W = 32;

  localparam int IBIAS_W  = 24;
  localparam int THRESH_W = 24;
  localparam int BAND_W   = 23;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd26214;
  localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 16'd4825;
  localparam logic [IBIAS_W-1:0]  IBIAS_RESET  = 24'd36000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd256;
  localparam logic [BAND_W-1:0]   BAND_RESET   = 23'd77;
  localparam logic [COUNT_W-1:0]  LIMIT_RESET  = 8'd12;
  localparam logic [COUNT_W-1:0]  TARE_N_RESET = 8'd6;

  localparam logic [COUNT_W-1:0]  COUNT_TOP  = 8'hff;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7fff_ffff;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 3'd0,
    REG_SLOPE  = 3'd1,
    REG_IBIAS  = 3'd2,
    REG_THRESH = 3'd3,
    REG_BAND   = 3'd4,
    REG_LIMIT  = 3'd5,
    REG_TARE_N = 3'd6
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_AVG,
    S_WSETUP,
    S_WDIV,
    S_WSAT,
    S_STAT,
    S_TDIV,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- sv/load_cell_weight_conditioner.sv -----
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    raw_sample
// result    out        out_valid / out_ready  weight, above_threshold, log_event,
//                                             tare_done, is_tared
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample passes through the steps mul, avg, wsetup, wdiv, wsat, stat and out, and
// its result is then registered for output; the sample that computes the tare bias
// also passes through tdiv after stat.
// wdiv and tdiv run on the shared restoring divider, one quotient bit a cycle,
// used for the weight division and then for the tare mean.
// in_ready is high only in idle; a new sample is taken while a result waits.
// a finished result holds in the last step until the output register is free.
// synchronous reset loads the register defaults; cfg_ready is always high.
`default_nettype none
module load_cell_weight_conditioner (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [lcwc_pkg::SAMPLE_BITS-1:0]     raw_sample,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [lcwc_pkg::WEIGHT_W-1:0]        weight,
  output logic                                 above_threshold,
  output logic                                 log_event,
  output logic                                 tare_done,
  output logic                                 is_tared,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [lcwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [lcwc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SB  = lcwc_pkg::SAMPLE_BITS;
  localparam int FB  = lcwc_pkg::FRACTION_BITS;
  localparam int AW  = lcwc_pkg::ACC_W;
  localparam int DW  = lcwc_pkg::DIV_W;
  localparam int QW  = lcwc_pkg::QX_W;
  localparam int PW  = lcwc_pkg::PROD_W;
  localparam int GW  = lcwc_pkg::GAIN_W;
  localparam int LW  = lcwc_pkg::SLOPE_W;
  localparam int CW  = lcwc_pkg::COUNT_W;
  localparam int TW  = lcwc_pkg::TSUM_W;
  localparam int WW  = lcwc_pkg::WEIGHT_W;
  localparam int NW  = lcwc_pkg::DCNT_W;

  lcwc_pkg::state_t state, state_next;

  // configuration registers
  logic [GW-1:0]                   ema_gain;
  logic [LW-1:0]                   slope;
  logic [lcwc_pkg::IBIAS_W-1:0]    initial_bias;
  logic [lcwc_pkg::THRESH_W-1:0]   weight_threshold;
  logic [lcwc_pkg::BAND_W-1:0]     stability_band;
  logic [CW-1:0]                   repeat_limit;
  logic [CW-1:0]                   tare_samples;

  // filter state
  logic [AW-1:0] average;
  logic [SB-1:0] bias;
  logic [WW-1:0] previous_weight;
  logic [CW-1:0] steady_count;
  logic [CW-1:0] tare_tally;
  logic [TW-1:0] tare_sum;
  logic          tared;

  // per-sample working registers
  logic [SB-1:0]        mag;
  logic signed [PW-1:0] prod;
  logic                 neg;
  logic [WW-1:0]        wgt;
  logic                 res_above;
  logic                 res_log;
  logic                 res_done;

  // shared divider
  logic [DW-1:0] quo;
  logic [LW-1:0] rem;
  logic [LW-1:0] dsr;
  logic [NW-1:0] dcnt;
  logic [LW:0]   rs;
  logic          ge;
  logic          div_last;

  logic [SB-1:0]        mag_in;
  logic [AW-1:0]        s_val;
  logic signed [AW:0]   dlt;
  logic signed [PW-1:0] acc;
  logic signed [AW:0]   diff;
  logic [AW:0]          diff_abs;
  logic [QW-1:0]        qx;
  logic                 pos_ovf;
  logic                 neg_ovf;
  logic [WW-1:0]        wgt_sat;
  logic                 above;
  logic signed [WW:0]   dw;
  logic [WW:0]          dw_abs;
  logic                 steady;
  logic [CW-1:0]        count_inc;
  logic                 tare_due;
  logic [CW-1:0]        tare_div;
  logic                 cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign mag_in = raw_sample[SB-1] ? (~raw_sample + SB'(1)) : raw_sample;
  assign s_val  = {mag, {FB{1'b0}}};
  assign dlt    = $signed({1'b0, s_val}) - $signed({1'b0, average});
  // avg*65536 + g*(s - avg) is the gain-weighted mix of sample and average
  assign acc    = $signed({2'b00, average, {GW{1'b0}}}) + prod;

  assign diff     = $signed({1'b0, average}) - $signed({1'b0, bias, {FB{1'b0}}});
  assign diff_abs = diff[AW] ? (~diff + (AW + 1)'(1)) : diff;

  assign rs       = {rem, quo[DW-1]};
  assign ge       = rs >= {1'b0, dsr};
  assign div_last = dcnt == NW'(DW - 1);

  assign qx      = QW'(quo);
  assign pos_ovf = |qx[QW-1:WW-1];
  assign neg_ovf = (|qx[QW-1:WW]) || (qx[WW-1] && (|qx[WW-2:0]));
  always_comb begin
    if (neg) begin
      wgt_sat = neg_ovf ? lcwc_pkg::WEIGHT_MIN : (~qx[WW-1:0] + WW'(1));
    end else begin
      wgt_sat = pos_ovf ? lcwc_pkg::WEIGHT_MAX : qx[WW-1:0];
    end
  end

  assign above = $signed(wgt) >
                 $signed({{(WW - lcwc_pkg::THRESH_W){weight_threshold[lcwc_pkg::THRESH_W-1]}},
                          weight_threshold});
  assign dw        = $signed({wgt[WW-1], wgt}) - $signed({previous_weight[WW-1], previous_weight});
  assign dw_abs    = dw[WW] ? (~dw + (WW + 1)'(1)) : dw;
  assign steady    = dw_abs < (WW + 1)'(stability_band);
  assign count_inc = (steady_count == lcwc_pkg::COUNT_TOP) ? steady_count
                                                          : steady_count + CW'(1);
  assign tare_due  = !tared && (tare_tally >= tare_samples);
  assign tare_div  = (tare_samples == '0) ? CW'(1) : tare_samples;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcwc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      lcwc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = lcwc_pkg::S_MUL;
      end
      lcwc_pkg::S_MUL:    state_next = lcwc_pkg::S_AVG;
      lcwc_pkg::S_AVG:    state_next = lcwc_pkg::S_WSETUP;
      lcwc_pkg::S_WSETUP: state_next = lcwc_pkg::S_WDIV;
      lcwc_pkg::S_WDIV: begin
        if (div_last) state_next = lcwc_pkg::S_WSAT;
      end
      lcwc_pkg::S_WSAT:   state_next = lcwc_pkg::S_STAT;
      lcwc_pkg::S_STAT:   state_next = tare_due ? lcwc_pkg::S_TDIV : lcwc_pkg::S_OUT;
      lcwc_pkg::S_TDIV: begin
        if (div_last) state_next = lcwc_pkg::S_OUT;
      end
      lcwc_pkg::S_OUT: begin
        if (!out_valid || out_ready) state_next = lcwc_pkg::S_IDLE;
      end
      default:            state_next = lcwc_pkg::S_IDLE;
    endcase
  end

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_gain         <= lcwc_pkg::GAIN_RESET;
      slope            <= lcwc_pkg::SLOPE_RESET;
      initial_bias     <= lcwc_pkg::IBIAS_RESET;
      weight_threshold <= lcwc_pkg::THRESH_RESET;
      stability_band   <= lcwc_pkg::BAND_RESET;
      repeat_limit     <= lcwc_pkg::LIMIT_RESET;
      tare_samples     <= lcwc_pkg::TARE_N_RESET;
      average          <= '0;
      bias             <= SB'(lcwc_pkg::IBIAS_RESET);
      previous_weight  <= '0;
      steady_count     <= '0;
      tare_tally       <= '0;
      tare_sum         <= '0;
      tared            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (lcwc_pkg::reg_index_t'(cfg_index))
          lcwc_pkg::REG_GAIN:   ema_gain <= cfg_data[GW-1:0];
          lcwc_pkg::REG_SLOPE:  slope <= cfg_data[LW-1:0];
          lcwc_pkg::REG_IBIAS: begin
            initial_bias <= cfg_data[lcwc_pkg::IBIAS_W-1:0];
            if (!tared) bias <= SB'(cfg_data[lcwc_pkg::IBIAS_W-1:0]);
          end
          lcwc_pkg::REG_THRESH: weight_threshold <= cfg_data[lcwc_pkg::THRESH_W-1:0];
          lcwc_pkg::REG_BAND:   stability_band <= cfg_data[lcwc_pkg::BAND_W-1:0];
          lcwc_pkg::REG_LIMIT:  repeat_limit <= cfg_data[CW-1:0];
          lcwc_pkg::REG_TARE_N: tare_samples <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        lcwc_pkg::S_AVG: average <= acc[AW+GW-1:GW];
        lcwc_pkg::S_STAT: begin
          previous_weight <= wgt;
          if (above) begin
            if (!steady) begin
              steady_count <= '0;
            end else if (count_inc > repeat_limit) begin
              steady_count <= '0;
            end else begin
              steady_count <= count_inc;
            end
          end
          if (!tared && !tare_due) begin
            tare_sum <= tare_sum + TW'(mag);
            if (tare_tally != lcwc_pkg::COUNT_TOP) tare_tally <= tare_tally + CW'(1);
          end
        end
        lcwc_pkg::S_TDIV: begin
          if (div_last) begin
            bias  <= {quo[SB-2:0], ge};
            tared <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath working registers and the shared divider
  always_ff @(posedge clk) begin
    unique case (state)
      lcwc_pkg::S_IDLE: begin
        if (in_valid) mag <= mag_in;
      end
      lcwc_pkg::S_MUL: prod <= PW'($signed({1'b0, ema_gain})) * PW'(dlt);
      lcwc_pkg::S_WSETUP: begin
        neg  <= diff[AW];
        quo  <= DW'(diff_abs[AW-1:0]);
        dsr  <= (slope == '0) ? LW'(1) : slope;
        rem  <= '0;
        dcnt <= '0;
      end
      lcwc_pkg::S_WDIV, lcwc_pkg::S_TDIV: begin
        rem  <= ge ? LW'(rs - {1'b0, dsr}) : rs[LW-1:0];
        quo  <= {quo[DW-2:0], ge};
        dcnt <= dcnt + NW'(1);
      end
      lcwc_pkg::S_WSAT: wgt <= wgt_sat;
      lcwc_pkg::S_STAT: begin
        res_above <= above;
        res_log   <= above && steady && (count_inc > repeat_limit);
        res_done  <= 1'b0;
        if (tare_due) begin
          quo  <= DW'(tare_sum);
          dsr  <= LW'(tare_div);
          rem  <= '0;
          dcnt <= '0;
        end
      end
      default: ;
    endcase
    if (state == lcwc_pkg::S_TDIV && div_last) res_done <= 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lcwc_pkg::S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lcwc_pkg::S_OUT && (!out_valid || out_ready)) begin
      weight          <= wgt;
      above_threshold <= res_above;
      log_event       <= res_log;
      tare_done       <= res_done;
      is_tared        <= tared;
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in progress");

  a_log_needs_above: assert property (@(posedge clk) disable iff (rst)
    out_valid && log_event |-> above_threshold)
    else $error("log event without weight above threshold");

  a_done_sets_tared: assert property (@(posedge clk) disable iff (rst)
    out_valid && tare_done |-> is_tared)
    else $error("tare done reported without tared flag");

  a_tared_sticky: assert property (@(posedge clk) disable iff (rst)
    tared |=> tared)
    else $error("tared flag cleared outside reset");

endmodule
`default_nettype wire
